// ===== src/bbuv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbuv_pkg
// Shared types and constants for the bounding box cylindrical uv mapper.
// ----------------------------------------------------------------------------
package bbuv_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int ANGLE_STEPS      = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;
    localparam int ITER_W           = $clog2(ANGLE_STEPS + 1);
    localparam int CORDIC_W         = 24;
    localparam int ANGLE_W          = 22;
    localparam int DIV_W            = COORD_WIDTH + 3;
    localparam int QUO_W            = 21;
    localparam int QCNT_W           = $clog2(DIV_W + 17);

    localparam logic signed [ANGLE_W-1:0] HALF_TURN = 22'sd524288;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_MAP     = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_V,
        ST_CORDIC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic [16:0] u_coord;
        logic [16:0] v_coord;
        logic        degenerate;
    } out_item_t;

    // atan(2^-i) in units of 2^-20 turn
    function automatic logic [17:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:  atan_entry = 18'd131072;
            5'd1:  atan_entry = 18'd77376;
            5'd2:  atan_entry = 18'd40884;
            5'd3:  atan_entry = 18'd20753;
            5'd4:  atan_entry = 18'd10417;
            5'd5:  atan_entry = 18'd5213;
            5'd6:  atan_entry = 18'd2607;
            5'd7:  atan_entry = 18'd1304;
            5'd8:  atan_entry = 18'd652;
            5'd9:  atan_entry = 18'd326;
            5'd10: atan_entry = 18'd163;
            5'd11: atan_entry = 18'd81;
            5'd12: atan_entry = 18'd41;
            5'd13: atan_entry = 18'd20;
            5'd14: atan_entry = 18'd10;
            5'd15: atan_entry = 18'd5;
            5'd16: atan_entry = 18'd3;
            5'd17: atan_entry = 18'd1;
            5'd18: atan_entry = 18'd1;
            default: atan_entry = 18'd0;
        endcase
    endfunction

endpackage

// ===== src/bbox_cylindrical_uv_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbox_cylindrical_uv_map
// Cylindrical uv mapping of Q16.16 vertices against a running bounding box.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid / in_stall / in_data) carries a command
// and a vertex; one output channel (out_valid / out_stall / out_data) carries
// u, v and a degenerate flag, one result per map command only.
// Measure and clear update the box at the transfer edge and give no result.
// A map goes through one restoring divider, one quotient bit per cycle:
// nx, ny and v in turn, then the CORDIC runs 16 steps and the end check,
// and the result is formed in ST_DONE into the output register. A
// degenerate box skips the arithmetic and its result goes through ST_DONE
// into the output register.
// The block holds one item at a time; in_stall is high while a map is in
// work or its result is not yet taken. The result holds in an output register
// while out_stall is high; the next item can be taken in the cycle after the
// result leaves, so no new map is taken before the last result has left.
// Reset empties the box (min at most positive, max at most negative) and
// drops any item in work.
// ----------------------------------------------------------------------------
module bbox_cylindrical_uv_map (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bbuv_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bbuv_pkg::out_item_t  out_data
);
    import bbuv_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] C_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_LO = {1'b1, {(CW-1){1'b0}}};

    // box storage
    logic signed [CW-1:0] min_reg [3];
    logic signed [CW-1:0] max_reg [3];
    // latched vertex
    logic signed [CW-1:0] p_reg [3];

    state_t state_reg, state_next;
    logic   out_valid_reg;
    out_item_t out_reg;

    // divider
    logic [DIV_W-1:0] dden_reg, drem_reg;
    logic [DIV_W+16:0] dshift_reg;
    logic [QUO_W-1:0] dquo_reg;
    logic [QCNT_W-1:0] dcnt_reg;
    logic              dneg_reg;
    logic              dsat_reg;
    logic signed [QUO_W:0] nx_reg, ny_reg;

    // cordic
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg;
    logic signed [ANGLE_W-1:0]  cz_reg;
    logic [ITER_W-1:0]          citer_reg;

    logic accept;
    logic [1:0] cmd;
    logic signed [CW-1:0] lc [3];

    // saturate a 32 bit coordinate to the coordinate width
    function automatic logic signed [CW-1:0] load_c(input logic signed [31:0] r);
        logic signed [63:0] s;
        begin
            s = 64'(r);
            if (s > 64'(C_HI))
                load_c = C_HI;
            else if (s < 64'(C_LO))
                load_c = C_LO;
            else
                load_c = CW'(s);
        end
    endfunction

    assign lc[0] = load_c(in_data.coord_x);
    assign lc[1] = load_c(in_data.coord_y);
    assign lc[2] = load_c(in_data.coord_z);
    assign cmd = in_data.command;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // box degenerate check
    logic degen;
    always_comb
    begin
        degen = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (max_reg[k] <= min_reg[k])
                degen = 1'b1;
        end
    end

    // numerators and denominators per divide pass (sign-magnitude)
    // x pass starts at the transfer, so it takes the incoming vertex
    logic signed [DIV_W-1:0] ax, ay, vn;
    logic [DIV_W-1:0] denx, deny, denv;
    always_comb
    begin
        ax = (DIV_W'(lc[0]) <<< 1) - DIV_W'(max_reg[0]) - DIV_W'(min_reg[0]);
        ay = (DIV_W'(p_reg[1]) <<< 1) - DIV_W'(max_reg[1]) - DIV_W'(min_reg[1]);
        vn = DIV_W'(max_reg[2]) + (DIV_W'(p_reg[2]) <<< 1)
           - DIV_W'(min_reg[2]) - (DIV_W'(min_reg[2]) <<< 1);
        denx = (DIV_W'(max_reg[0]) - DIV_W'(min_reg[0])) << 1;
        deny = (DIV_W'(max_reg[1]) - DIV_W'(min_reg[1])) << 1;
        denv = (DIV_W'(max_reg[2]) - DIV_W'(min_reg[2])) << 2;
    end

    // one restoring divide step on the shifted numerator
    logic [DIV_W:0] trial;
    logic [DIV_W-1:0] rem_step;
    logic             qbit;
    always_comb
    begin
        trial    = {drem_reg, dshift_reg[DIV_W+16]};
        qbit     = (trial >= {1'b0, dden_reg});
        rem_step = qbit ? DIV_W'(trial - {1'b0, dden_reg}) : DIV_W'(trial);
    end

    logic div_last;
    assign div_last = (dcnt_reg == QCNT_W'(DIV_W + 16));

    // cordic step
    logic [4:0] ci5;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic [17:0] at;
    always_comb
    begin
        ci5 = 5'(citer_reg);
        xs  = cx_reg >>> ci5;
        ys  = cy_reg >>> ci5;
        at  = atan_entry(ci5);
    end

    // angle to u
    logic signed [ANGLE_W-1:0] ang;
    logic [16:0] u_val;
    logic [ANGLE_W-1:0] ang_r;
    always_comb
    begin
        ang   = cz_reg + HALF_TURN;
        ang_r = ANGLE_W'(ang) + ANGLE_W'(8);
        if (ang <= 0)
            u_val = 17'd0;
        else if ((ang_r >> 4) > ANGLE_W'(65536))
            u_val = 17'd65536;
        else
            u_val = 17'(ang_r >> 4);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_MAP)
                    state_next = degen ? ST_DONE : ST_DIV_X;
            end
            ST_DIV_X:  if (div_last) state_next = ST_DIV_Y;
            ST_DIV_Y:  if (div_last) state_next = ST_DIV_V;
            ST_DIV_V:  if (div_last) state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                if (citer_reg == ITER_W'(ANGLE_STEPS))
                    state_next = ST_DONE;
            end
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // load one divide pass
    function automatic logic [DIV_W-1:0] mag(input logic signed [DIV_W-1:0] a);
        mag = a[DIV_W-1] ? DIV_W'(-a) : DIV_W'(a);
    endfunction

    // signed normalized value with saturation at the limit
    function automatic logic signed [QUO_W:0] sq(input logic s, input logic [QUO_W-1:0] q,
                                                   input logic b, input logic [QUO_W-1:0] lim,
                                                   input logic neg);
        logic [QUO_W:0] full;
        logic [QUO_W:0] m;
        begin
            full = {q, b};
            if (s || full >= {1'b0, lim})
                m = {1'b0, lim};
            else
                m = full;
            sq = neg ? -$signed(m) : $signed(m);
        end
    endfunction

    // v clamp to 0..1
    function automatic logic [16:0] vsat(input logic s, input logic [QUO_W-1:0] q,
                                         input logic b, input logic neg);
        logic [QUO_W:0] full;
        begin
            full = {q, b};
            if (neg || full == '0)
                vsat = 17'd0;
            else if (s || full >= (QUO_W + 1)'(65536))
                vsat = 17'd65536;
            else
                vsat = 17'(full);
        end
    endfunction

    // box update and output valid flag
    logic degen_reg;
    logic [16:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                min_reg[k] <= C_HI;
                max_reg[k] <= C_LO;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                case (cmd)
                    CMD_MEASURE:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (lc[k] < min_reg[k]) min_reg[k] <= lc[k];
                            if (lc[k] > max_reg[k]) max_reg[k] <= lc[k];
                        end
                    end
                    CMD_CLEAR:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            min_reg[k] <= C_HI;
                            max_reg[k] <= C_LO;
                        end
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
                p_reg[k] <= lc[k];
            degen_reg <= degen;
        end
        // start x divide or chain to next pass
        if (accept && cmd == CMD_MAP)
        begin
            dshift_reg <= {mag(ax), 16'd0};
            dden_reg   <= denx;
            dneg_reg   <= ax[DIV_W-1];
            drem_reg   <= '0;
            dquo_reg   <= '0;
            dsat_reg   <= 1'b0;
            dcnt_reg   <= '0;
        end
        else if (state_reg == ST_DIV_X || state_reg == ST_DIV_Y || state_reg == ST_DIV_V)
        begin
            if (!div_last)
            begin
                drem_reg   <= rem_step;
                dshift_reg <= dshift_reg << 1;
                dquo_reg   <= {dquo_reg[QUO_W-2:0], qbit};
                if (dquo_reg[QUO_W-1])
                    dsat_reg <= 1'b1;
                dcnt_reg   <= dcnt_reg + 1'b1;
            end
            else
            begin
                dcnt_reg <= '0;
                drem_reg <= '0;
                dquo_reg <= '0;
                dsat_reg <= 1'b0;
                if (state_reg == ST_DIV_X)
                begin
                    nx_reg     <= sq(dsat_reg, dquo_reg, qbit, 21'd1048576, dneg_reg);
                    dshift_reg <= {mag(ay), 16'd0};
                    dden_reg   <= deny;
                    dneg_reg   <= ay[DIV_W-1];
                end
                else if (state_reg == ST_DIV_Y)
                begin
                    ny_reg     <= sq(dsat_reg, dquo_reg, qbit, 21'd1048576, dneg_reg);
                    dshift_reg <= {mag(vn), 16'd0};
                    dden_reg   <= denv;
                    dneg_reg   <= vn[DIV_W-1];
                end
                else
                begin
                    v_reg <= vsat(dsat_reg, dquo_reg, qbit, dneg_reg);
                end
            end
        end
        // cordic
        if (state_reg == ST_DIV_V && div_last)
        begin
            citer_reg <= '0;
            if (nx_reg < 0)
            begin
                cz_reg <= (ny_reg >= 0) ? HALF_TURN : -HALF_TURN;
                cx_reg <= CORDIC_W'(-nx_reg);
                cy_reg <= CORDIC_W'(-ny_reg);
            end
            else
            begin
                cz_reg <= '0;
                cx_reg <= CORDIC_W'(nx_reg);
                cy_reg <= CORDIC_W'(ny_reg);
            end
        end
        else if (state_reg == ST_CORDIC && citer_reg != ITER_W'(ANGLE_STEPS))
        begin
            citer_reg <= citer_reg + 1'b1;
            if (cy_reg >= 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + ANGLE_W'(at);
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - ANGLE_W'(at);
            end
        end
        // result capture
        if (state_reg == ST_DONE)
        begin
            if (degen_reg)
                out_reg <= '{u_coord: 17'd0, v_coord: 17'd0, degenerate: 1'b1};
            else if (nx_reg == 0 && ny_reg == 0)
                out_reg <= '{u_coord: 17'd32768, v_coord: v_reg, degenerate: 1'b0};
            else
                out_reg <= '{u_coord: u_val, v_coord: v_reg, degenerate: 1'b0};
        end
    end

`ifndef NO_ASSERTIONS
    // a result appears only after the last step of a map
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result without finished map");
    // held result stays while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");
    // no new item while busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input open during map");
    // box on axis 0 stays put during the CORDIC part of a map
    a_box: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CORDIC |=> $stable(min_reg[0]) && $stable(max_reg[0]))
        else $error("box changed during map");
`endif

endmodule
